>>> rtl/tme_pkg.sv
package tme_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CFG_GRAVITY   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_INIT_GAIN = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_INIT_COV  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_MEAS_NOISE = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_MAX_AGE   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_MIN_DELAY = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_MODEL     = 3'd6;

  localparam logic [23:0] GRAVITY_RST    = 24'd642908;
  localparam logic [23:0] INIT_GAIN_RST  = 24'd1285816;
  localparam logic [23:0] INIT_COV_RST   = 24'd65536;
  localparam logic [23:0] MEAS_NOISE_RST = 24'd19661;
  localparam logic [31:0] MAX_AGE_RST    = 32'd1000000;
  localparam logic [31:0] MIN_DELAY_RST  = 32'd35000;

  localparam logic signed [17:0] TH_MAX = 18'sd131071;
  localparam logic signed [17:0] TH_MIN = -18'sd131072;

  typedef struct packed {
    logic               op;
    logic [31:0]        time_us;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [23:0] want_acc_x;
    logic signed [23:0] want_acc_y;
    logic signed [23:0] want_acc_z;
    logic signed [23:0] measured_acc_z;
  } tme_in_t;

  typedef struct packed {
    logic signed [17:0] thrust;
    logic               updated;
    logic [23:0]        gain_estimate;
    logic [15:0]        hover_fraction;
  } tme_out_t;

  typedef enum logic [4:0] {
    S_IDLE, S_BODY, S_DOT, S_DOTSUM, S_TDIV, S_TSAT, S_PUSH,
    S_QREAD, S_QWAIT, S_QCHK, S_KDIV, S_INNOV, S_KMUL, S_GUPD,
    S_HDIV, S_CLAMP, S_SKIP_H, S_OUT
  } tme_state_t;

  typedef enum logic [3:0] {
    C_NONE, C_BODY, C_DOT, C_DOTSUM, C_TDIV_GO, C_TSAT, C_PUSH,
    C_QREAD, C_QCHK, C_KDIV_GO, C_INNOV, C_KMUL, C_GUPD, C_HDIV_GO, C_CLAMP,
    C_SKIP_H
  } tme_cmd_t;

  typedef struct packed {
    logic div_done;
    logic q_empty;
    logic too_old;
    logic too_young;
    logic model_acc;
  } tme_stat_t;

endpackage

>>> rtl/tme_if.sv
interface tme_if #(parameter int W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/tme_ram.sv
module tme_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/tme_div.sv
// Restoring divider, one quotient bit a cycle: quotient = num / den, unsigned.
module tme_div #(
  parameter int NW = 48,
  parameter int DW = 40
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] quo_r, quo_nxt;
  logic [DW:0]   rem_r, rem_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, done_r, done_nxt;
  logic [DW:0]   trial;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = '0;
    if (start) begin
      quo_nxt  = num;
      rem_nxt  = '0;
      den_nxt  = den;
      cnt_nxt  = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // shift one numerator bit in, subtract where it fits
      trial = {rem_r[DW-1:0], quo_r[NW-1]};
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        quo_nxt = {quo_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;
endmodule

>>> rtl/tme_ctrl.sv
module tme_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  logic                in_op,
  input  logic                out_busy,
  input  tme_pkg::tme_stat_t  stat,
  output logic                in_ready,
  output logic                out_load,
  output tme_pkg::tme_cmd_t   cmd
);
  import tme_pkg::*;

  tme_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // sequence one item through the datapath
  always_comb begin
    state_nxt = state_r;
    cmd       = C_NONE;
    in_ready  = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          state_nxt = in_op ? S_QREAD : S_BODY;
        end
      end
      S_BODY:   begin cmd = C_BODY;   state_nxt = S_DOT; end
      S_DOT:    begin cmd = C_DOT;    state_nxt = S_DOTSUM; end
      S_DOTSUM: begin cmd = C_DOTSUM; state_nxt = S_TDIV; end
      S_TDIV: begin
        cmd = C_TDIV_GO;
        state_nxt = S_TSAT;
      end
      S_TSAT: begin
        if (stat.div_done) begin
          cmd = C_TSAT;
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin cmd = C_PUSH; state_nxt = S_OUT; end
      S_QREAD: begin
        if (stat.q_empty) begin
          state_nxt = S_OUT;
        end else begin
          cmd = C_QREAD;
          state_nxt = S_QWAIT;
        end
      end
      S_QWAIT: state_nxt = S_QCHK;
      S_QCHK: begin
        priority if (stat.too_old) begin
          cmd = C_QCHK;
          state_nxt = S_QREAD;
        end else if (stat.too_young) begin
          state_nxt = S_OUT;
        end else if (stat.model_acc) begin
          cmd = C_SKIP_H;
          state_nxt = S_SKIP_H;
        end else begin
          cmd = C_KDIV_GO;
          state_nxt = S_KDIV;
        end
      end
      S_KDIV: begin
        if (stat.div_done) begin
          cmd = C_INNOV;
          state_nxt = S_INNOV;
        end
      end
      S_INNOV: begin cmd = C_KMUL; state_nxt = S_KMUL; end
      S_KMUL:  begin cmd = C_GUPD; state_nxt = S_GUPD; end
      S_GUPD:  begin cmd = C_HDIV_GO; state_nxt = S_HDIV; end
      S_HDIV: begin
        if (stat.div_done) begin
          cmd = C_CLAMP;
          state_nxt = S_CLAMP;
        end
      end
      S_CLAMP: state_nxt = S_OUT;
      S_SKIP_H: begin
        if (stat.div_done) begin
          cmd = C_HDIV_GO;
          state_nxt = S_HDIV;
        end
      end
      S_OUT: begin
        if (!out_busy) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

>>> rtl/tme_dp.sv
module tme_dp #(
  parameter int QUEUE_DEPTH = 100
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_fire,
  input  tme_pkg::tme_in_t             in_item,
  input  logic                         cfg_we,
  input  logic [tme_pkg::CfgIdxW-1:0]  cfg_idx,
  input  logic [tme_pkg::CfgDataW-1:0] cfg_data,
  input  tme_pkg::tme_cmd_t            cmd,
  output tme_pkg::tme_stat_t           stat,
  output tme_pkg::tme_out_t            result
);
  import tme_pkg::*;

  localparam int QAW = $clog2(QUEUE_DEPTH);
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  // configuration
  logic [23:0] gravity_r, init_gain_r, init_cov_r, meas_noise_r;
  logic [31:0] max_age_r, min_delay_r;
  logic        model_r;

  // estimator state
  logic [23:0] gain_r, gain_nxt, cov_r, cov_nxt;
  logic [QAW-1:0] head_r, head_nxt;
  logic [QCW-1:0] count_r, count_nxt;

  tme_in_t item_r;

  logic signed [33:0] bx_r, by_r, bz_r;
  logic signed [59:0] px_r, py_r, pz_r;
  logic signed [61:0] dot_r;
  logic signed [17:0] thr_r, thr_nxt;
  logic               updated_r, updated_nxt;
  logic [15:0]        hover_r, hover_nxt;
  logic signed [17:0] qthr;
  logic [31:0]        qtime;
  logic [31:0]        age;
  logic signed [40:0] innov_r;
  logic signed [59:0] kinn_r;
  logic signed [41:0] kthr_r;

  // shared divider
  logic        div_start;
  logic [60:0] div_num, div_quo;
  logic [36:0] div_den;
  logic        div_done;

  tme_div #(.NW(61), .DW(37)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  // queue memories
  logic           q_we;
  logic [QAW-1:0] q_waddr;

  tme_ram #(.WIDTH(18), .DEPTH(QUEUE_DEPTH)) u_qthr (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(thr_r),
    .raddr(head_r), .rdata(qthr)
  );

  tme_ram #(.WIDTH(32), .DEPTH(QUEUE_DEPTH)) u_qtime (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(item_r.time_us),
    .raddr(head_r), .rdata(qtime)
  );

  function automatic logic [QAW-1:0] wrap_inc(input logic [QAW-1:0] a);
    return (a == QAW'(QUEUE_DEPTH - 1)) ? '0 : a + QAW'(1);
  endfunction

  logic [QAW:0] tail_sum;
  logic [QAW-1:0] tail_pos;
  logic         full;
  logic [60:0]  dot_mag;
  logic [35:0]  tdiv_den;
  logic [60:0]  tq_signed_mag;
  logic signed [61:0] tq;
  logic [24:0]  pr_sum;
  logic signed [58:0] gnew;
  logic signed [42:0] om;
  logic signed [66:0] np;
  logic [27:0]  g5, g4;
  logic [27:0]  g10;
  logic [16:0]  kq;

  // a full queue overwrites its oldest entry, which sits at the head
  assign age     = item_r.time_us - qtime;
  assign full    = (count_r == QCW'(QUEUE_DEPTH));
  assign tail_sum = {1'b0, head_r} + (full ? QAW'(0) : count_r[QAW-1:0]);
  assign tail_pos = (tail_sum >= (QAW+1)'(QUEUE_DEPTH))
                  ? QAW'(tail_sum - (QAW+1)'(QUEUE_DEPTH)) : tail_sum[QAW-1:0];

  assign stat.div_done  = div_done;
  assign stat.q_empty   = (count_r == '0);
  assign stat.too_old   = (age > max_age_r);
  assign stat.too_young = (age < min_delay_r);
  assign stat.model_acc = model_r;

  assign dot_mag  = dot_r[61] ? 61'(-dot_r) : 61'(dot_r);
  assign tdiv_den = {(gain_r == '0) ? 24'd1 : gain_r, 12'd0};
  assign pr_sum   = {1'b0, cov_r} + {1'b0, meas_noise_r};
  assign kq       = div_quo[16:0];
  assign g5       = 28'({gravity_r, 2'b0}) + 28'(gravity_r);
  assign g10      = 28'({gravity_r, 3'b0}) + 28'({gravity_r, 1'b0});

  always_comb begin
    tq_signed_mag = div_quo;
    tq = dot_r[61] ? -$signed({1'b0, tq_signed_mag}) : $signed({1'b0, tq_signed_mag});
  end

  // divider operand select; a zero divisor still runs and its quotient is dropped
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    unique case (cmd)
      C_TDIV_GO: begin
        div_start = 1'b1;
        div_num   = dot_mag;
        div_den   = {1'b0, tdiv_den};
      end
      C_KDIV_GO: begin
        div_start = 1'b1;
        div_num   = 61'({cov_r, 16'd0});
        div_den   = 37'(pr_sum);
      end
      C_HDIV_GO, C_SKIP_H: begin
        div_start = 1'b1;
        div_num   = 61'({gravity_r, 16'd0});
        div_den   = 37'(gain_r);
      end
      default: ;
    endcase
  end

  logic kzero_r;
  logic hzero_r;

  // datapath register updates
  always_comb begin
    gain_nxt    = gain_r;
    cov_nxt     = cov_r;
    head_nxt    = head_r;
    count_nxt   = count_r;
    thr_nxt     = thr_r;
    updated_nxt = updated_r;
    hover_nxt   = hover_r;
    q_we        = 1'b0;
    q_waddr     = tail_pos;
    gnew        = '0;
    om          = '0;
    np          = '0;
    g4          = 28'({gain_r, 2'b0});
    if (in_fire) begin
      thr_nxt     = '0;
      updated_nxt = 1'b0;
      hover_nxt   = '0;
    end
    unique case (cmd)
      C_TSAT: begin
        if (tq > 62'(TH_MAX))      thr_nxt = TH_MAX;
        else if (tq < 62'(TH_MIN)) thr_nxt = TH_MIN;
        else                       thr_nxt = 18'(tq);
      end
      C_PUSH: begin
        q_we = 1'b1;
        if (full) begin
          head_nxt = wrap_inc(head_r);
        end else begin
          count_nxt = count_r + QCW'(1);
        end
      end
      C_QCHK: begin
        head_nxt  = wrap_inc(head_r);
        count_nxt = count_r - QCW'(1);
      end
      C_SKIP_H: begin
        head_nxt    = wrap_inc(head_r);
        count_nxt   = count_r - QCW'(1);
        updated_nxt = 1'b1;
      end
      C_KDIV_GO: begin
        head_nxt    = wrap_inc(head_r);
        count_nxt   = count_r - QCW'(1);
        updated_nxt = 1'b1;
        thr_nxt     = qthr;
      end
      C_GUPD: begin
        gnew = $signed({35'd0, gain_r}) + 59'(kinn_r >>> 16);
        if (kinn_r < 0 && kinn_r[15:0] != '0) gnew = gnew + 59'sd1;
        if (gnew < 0)                 gain_nxt = '0;
        else if (gnew > 59'sd16777215) gain_nxt = '1;
        else                          gain_nxt = 24'(gnew);
        om = 43'sd65536 - 43'(kthr_r >>> 16)
           - ((kthr_r < 0 && kthr_r[15:0] != '0) ? 43'sd1 : 43'sd0);
        np = om * $signed({1'b0, cov_r});
        np = (np < 0) ? -((-np) >>> 16) : (np >>> 16);
        if (np < 0)                    cov_nxt = '0;
        else if (np > 67'sd16777215)   cov_nxt = '1;
        else                           cov_nxt = 24'(np);
      end
      C_CLAMP: begin
        hover_nxt = hzero_r ? 16'hFFFF
                  : ((div_quo > 61'd65535) ? 16'hFFFF : div_quo[15:0]);
        if (!model_r) begin
          if (g5 > g4) begin
            gain_nxt = 24'(g5 >> 2);
          end else if (g10 > 28'(gain_r)) begin
            gain_nxt = gain_r;
          end else if (g10 < 28'(gain_r)) begin
            gain_nxt = (g10 > 28'hFFFFFF) ? 24'hFFFFFF : 24'(g10);
          end
        end
      end
      default: ;
    endcase
    if (cfg_we && cfg_idx == CFG_INIT_GAIN) gain_nxt = cfg_data[23:0];
    if (cfg_we && cfg_idx == CFG_INIT_COV)  cov_nxt  = cfg_data[23:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gravity_r    <= GRAVITY_RST;
      init_gain_r  <= INIT_GAIN_RST;
      init_cov_r   <= INIT_COV_RST;
      meas_noise_r <= MEAS_NOISE_RST;
      max_age_r    <= MAX_AGE_RST;
      min_delay_r  <= MIN_DELAY_RST;
      model_r      <= 1'b0;
      gain_r       <= INIT_GAIN_RST;
      cov_r        <= INIT_COV_RST;
      head_r       <= '0;
      count_r      <= '0;
    end else begin
      gain_r  <= gain_nxt;
      cov_r   <= cov_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_GRAVITY:    gravity_r    <= cfg_data[23:0];
          CFG_INIT_GAIN:  init_gain_r  <= cfg_data[23:0];
          CFG_INIT_COV:   init_cov_r   <= cfg_data[23:0];
          CFG_MEAS_NOISE: meas_noise_r <= cfg_data[23:0];
          CFG_MAX_AGE:    max_age_r    <= cfg_data;
          CFG_MIN_DELAY:  min_delay_r  <= cfg_data;
          CFG_MODEL:      model_r      <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // payload pipeline of one item
  always_ff @(posedge clk) begin
    if (in_fire) item_r <= in_item;
    thr_r     <= thr_nxt;
    updated_r <= updated_nxt;
    hover_r   <= hover_nxt;
    unique case (cmd)
      C_BODY: begin
        bx_r <= 34'(2 * (34'(item_r.quat_x * item_r.quat_z)
                       + 34'(item_r.quat_w * item_r.quat_y)));
        by_r <= 34'(2 * (34'(item_r.quat_y * item_r.quat_z)
                       - 34'(item_r.quat_w * item_r.quat_x)));
        bz_r <= 34'sd268435456 - 34'(2 * (34'(item_r.quat_x * item_r.quat_x)
                       + 34'(item_r.quat_y * item_r.quat_y)));
      end
      C_DOT: begin
        px_r <= 60'(item_r.want_acc_x * bx_r);
        py_r <= 60'(item_r.want_acc_y * by_r);
        pz_r <= 60'(item_r.want_acc_z * bz_r);
      end
      C_DOTSUM: dot_r <= 62'(px_r) + 62'(py_r) + 62'(pz_r);
      C_KDIV_GO: kzero_r <= (pr_sum == '0);
      C_INNOV: begin
        innov_r <= 41'(item_r.measured_acc_z)
                 - ((42'(thr_r) * $signed({1'b0, gain_r})) < 0
                    ? -41'((-(42'(thr_r) * $signed({1'b0, gain_r}))) >>> 16)
                    : 41'((42'(thr_r) * $signed({1'b0, gain_r})) >>> 16));
        kthr_r  <= $signed({1'b0, (kzero_r ? 17'd0 : kq)}) * 42'(thr_r);
      end
      C_KMUL: kinn_r <= $signed({1'b0, (kzero_r ? 17'd0 : kq)}) * 60'(innov_r);
      C_HDIV_GO, C_SKIP_H: hzero_r <= (gain_r == '0);
      default: ;
    endcase
  end

  assign result.thrust         = (cmd == C_NONE && updated_r) ? 18'sd0 : thr_r;
  assign result.updated        = updated_r;
  assign result.gain_estimate  = gain_r;
  assign result.hover_fraction = hover_r;
endmodule

>>> rtl/thrust_mapping_estimator.sv
// Op 0: thrust is a quotient of the 61-step serial divider. Op 1: stale queue
// entries are dropped one by one; a popped entry then runs two serial divisions,
// Kalman gain then hover fraction (hover fraction twice when CFG_MODEL is set).
// Throughput: one item at a time; the next is taken once the previous result has
// moved into the output register, which waits while an earlier result is unread.
// Reset (synchronous, rst_n low): registers to defaults, queue empty, gain and
// covariance to their starting values.
module thrust_mapping_estimator #(
  parameter int QUEUE_DEPTH = 100
) (
  input  logic                         clk,
  input  logic                         rst_n,
  tme_if.sink                          in_ch,
  tme_if.source                        out_ch,
  input  logic                         cfg_we,
  input  logic [tme_pkg::CfgIdxW-1:0]  cfg_idx,
  input  logic [tme_pkg::CfgDataW-1:0] cfg_data
);
  import tme_pkg::*;

  tme_cmd_t  cmd;
  tme_stat_t stat;
  tme_out_t  result;
  tme_out_t  out_r;
  logic      out_valid_r;
  logic      in_fire, out_load, in_rdy;

  assign in_fire     = in_ch.valid && in_rdy;
  assign in_ch.ready = in_rdy;

  tme_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_op(in_ch.data[$bits(tme_in_t)-1]),
    .out_busy(out_valid_r && !out_ch.ready), .stat(stat), .in_ready(in_rdy),
    .out_load(out_load), .cmd(cmd)
  );

  tme_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_item(tme_in_t'(in_ch.data)),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .cmd(cmd), .stat(stat), .result(result)
  );

  // hold the result beat until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (out_load) out_r <= result;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;
endmodule
